/* hdl/ddsbg_pkg.sv */
package ddsbg_pkg;

  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_NUM_TABLES  = 3;
  localparam int DEF_PHASE_WIDTH = 32;

  localparam int WORD_W      = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int COUNT_W     = 32;
  localparam int STEP_W      = 32;
  localparam int SEL_CFG_W   = 2;
  localparam int TID_W       = 2;
  localparam int TIDX_W      = 12;

  localparam logic [WORD_W-1:0] IDLE_WORD_FIRST  = WORD_W'(45056 + 2048);
  localparam logic [WORD_W-1:0] IDLE_WORD_SECOND = WORD_W'(12288 + 2048);

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_A  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_B  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEL_A   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEL_B   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST   = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    POS_WAVE_A = 2'd0,
    POS_WAVE_B = 2'd1,
    POS_IDLE_1 = 2'd2,
    POS_IDLE_2 = 2'd3
  } pos_t;

  // one tick's word group handed to the output stage
  typedef struct packed {
    logic load;
    logic idle_only;
    logic wave_only;
  } group_t;

endpackage

/* hdl/dual_dds_burst_generator.sv */
// Two-channel DDS with burst control. Operation words arrive on the in_*
// channel (sample tick, table word write, start, stop) and DAC command words
// leave on the out_* channel, one word per cycle while out_stall is low. A
// sample tick gives two words (first channel with latch_before set, then
// second channel), or four at the end of a burst when two mid-scale idle
// words follow; a tick while stopped gives the two idle words only. A tick
// holds the single output word register until its last word is taken;
// writes, start and stop produce nothing. A tick's first word comes through
// the operation register, then the registered read of the waveform RAM.
// The waveform store is one RAM with a write port and two read ports; its
// contents are undefined after reset and need no clearing, but a table
// entry must be written before a tick reads it. Configuration is taken on
// cfg_write at any cycle but must only change while the block is idle.
module dual_dds_burst_generator #(
  parameter int TABLE_DEPTH = ddsbg_pkg::DEF_TABLE_DEPTH,
  parameter int NUM_TABLES  = ddsbg_pkg::DEF_NUM_TABLES,
  parameter int PHASE_WIDTH = ddsbg_pkg::DEF_PHASE_WIDTH,
  localparam int SEL_W   = $clog2(NUM_TABLES),
  localparam int INDEX_W = $clog2(TABLE_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ddsbg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ddsbg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic [ddsbg_pkg::TID_W-1:0]       table_id,
  input  logic [ddsbg_pkg::TIDX_W-1:0]      table_index,
  input  logic [ddsbg_pkg::WORD_W-1:0]      table_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ddsbg_pkg::WORD_W-1:0]      dac_word,
  output logic                              latch_before,
  output logic                              last
);

  import ddsbg_pkg::*;

  localparam int AW        = SEL_W + INDEX_W;
  localparam int RAM_DEPTH = NUM_TABLES * (2 ** INDEX_W);

  group_t            grp;
  logic              b_free;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr_a;
  logic [AW-1:0]     ram_raddr_b;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;

  ddsbg_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_TABLES  (NUM_TABLES),
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .table_id    (table_id),
    .table_index (table_index),
    .table_word  (table_word),
    .b_free      (b_free),
    .grp         (grp),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b)
  );

  ddsbg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  ddsbg_out u_out (
    .clk          (clk),
    .rst          (rst),
    .grp          (grp),
    .rd_a         (rd_a),
    .rd_b         (rd_b),
    .b_free       (b_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dac_word     (dac_word),
    .latch_before (latch_before),
    .last         (last)
  );

endmodule

/* hdl/ddsbg_ram.sv */
module ddsbg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* hdl/ddsbg_ctrl.sv */
module ddsbg_ctrl #(
  parameter int TABLE_DEPTH = ddsbg_pkg::DEF_TABLE_DEPTH,
  parameter int NUM_TABLES  = ddsbg_pkg::DEF_NUM_TABLES,
  parameter int PHASE_WIDTH = ddsbg_pkg::DEF_PHASE_WIDTH,
  localparam int SEL_W   = $clog2(NUM_TABLES),
  localparam int INDEX_W = $clog2(TABLE_DEPTH),
  localparam int AW      = SEL_W + INDEX_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ddsbg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ddsbg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic [ddsbg_pkg::TID_W-1:0]       table_id,
  input  logic [ddsbg_pkg::TIDX_W-1:0]      table_index,
  input  logic [ddsbg_pkg::WORD_W-1:0]      table_word,
  input  logic                              b_free,
  output ddsbg_pkg::group_t                 grp,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [ddsbg_pkg::WORD_W-1:0]      ram_wdata,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_raddr_a,
  output logic [AW-1:0]                     ram_raddr_b
);

  import ddsbg_pkg::*;

  // top address bits of the phase, floor(log2(depth))
  localparam int AB = $clog2(TABLE_DEPTH + 1) - 1;

  logic [STEP_W-1:0]      step_a;
  logic [STEP_W-1:0]      step_b;
  logic [SEL_CFG_W-1:0]   sel_a;
  logic [SEL_CFG_W-1:0]   sel_b;
  logic [COUNT_W-1:0]     burst_length;

  logic [PHASE_WIDTH-1:0] phase_a;
  logic [PHASE_WIDTH-1:0] phase_b;
  logic [COUNT_W-1:0]     ticks_done;
  logic                   running;

  logic                   a_valid;
  op_t                    a_op;
  logic [TID_W-1:0]       a_tid;
  logic [TIDX_W-1:0]      a_tidx;
  logic [WORD_W-1:0]      a_word;

  logic                   a_fire;
  logic [PHASE_WIDTH-1:0] sum_a;
  logic [PHASE_WIDTH-1:0] sum_b;
  logic [COUNT_W-1:0]     ticks_inc;
  logic                   burst_on;
  logic                   burst_over;
  logic                   burst_final;
  logic [SEL_W-1:0]       sel_a_eff;
  logic [SEL_W-1:0]       sel_b_eff;

  assign a_fire   = a_valid && (a_op != OP_TICK || b_free);
  assign in_stall = a_valid && !a_fire;

  assign sum_a       = phase_a + PHASE_WIDTH'(step_a);
  assign sum_b       = phase_b + PHASE_WIDTH'(step_b);
  assign ticks_inc   = ticks_done + COUNT_W'(1);
  assign burst_on    = burst_length != '0;
  assign burst_over  = burst_on && (ticks_done >= burst_length);
  assign burst_final = burst_on && (ticks_inc == burst_length);

  assign sel_a_eff = (32'(sel_a) >= NUM_TABLES) ? SEL_W'(NUM_TABLES - 1) : SEL_W'(sel_a);
  assign sel_b_eff = (32'(sel_b) >= NUM_TABLES) ? SEL_W'(NUM_TABLES - 1) : SEL_W'(sel_b);

  always_comb begin
    grp.load      = a_fire && (a_op == OP_TICK);
    grp.idle_only = !running || burst_over;
    grp.wave_only = !burst_final;
  end

  assign ram_re      = grp.load && !grp.idle_only;
  assign ram_raddr_a = {sel_a_eff, INDEX_W'(sum_a[PHASE_WIDTH-1 -: AB])};
  assign ram_raddr_b = {sel_b_eff, INDEX_W'(sum_b[PHASE_WIDTH-1 -: AB])};

  assign ram_we    = a_fire && (a_op == OP_WRITE) && (32'(a_tid) < NUM_TABLES)
                     && (32'(a_tidx) < TABLE_DEPTH);
  assign ram_waddr = {SEL_W'(a_tid), INDEX_W'(a_tidx)};
  assign ram_wdata = a_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_a       <= '0;
      step_b       <= '0;
      sel_a        <= SEL_CFG_W'(0);
      sel_b        <= SEL_CFG_W'(1);
      burst_length <= '0;
      phase_a      <= '0;
      phase_b      <= '0;
      ticks_done   <= '0;
      running      <= 1'b0;
      a_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_STEP_A: step_a       <= cfg_data[STEP_W-1:0];
          REG_STEP_B: step_b       <= cfg_data[STEP_W-1:0];
          REG_SEL_A:  sel_a        <= cfg_data[SEL_CFG_W-1:0];
          REG_SEL_B:  sel_b        <= cfg_data[SEL_CFG_W-1:0];
          REG_BURST:  burst_length <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (!a_valid || a_fire) begin
        a_valid <= in_valid;
      end

      if (a_fire) begin
        unique case (a_op)
          OP_START: running <= 1'b1;
          OP_STOP:  running <= 1'b0;
          OP_WRITE: ;
          OP_TICK: begin
            if (running) begin
              if (burst_over || burst_final) begin
                running    <= 1'b0;
                ticks_done <= '0;
                phase_a    <= '0;
                phase_b    <= '0;
              end else begin
                phase_a <= sum_a;
                phase_b <= sum_b;
                if (burst_on) begin
                  ticks_done <= ticks_inc;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!a_valid || a_fire) begin
      a_op   <= op_t'(operation);
      a_tid  <= table_id;
      a_tidx <= table_index;
      a_word <= table_word;
    end
  end

endmodule

/* hdl/ddsbg_out.sv */
module ddsbg_out (
  input  logic                         clk,
  input  logic                         rst,
  input  ddsbg_pkg::group_t            grp,
  input  logic [ddsbg_pkg::WORD_W-1:0] rd_a,
  input  logic [ddsbg_pkg::WORD_W-1:0] rd_b,
  output logic                         b_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ddsbg_pkg::WORD_W-1:0] dac_word,
  output logic                         latch_before,
  output logic                         last
);

  import ddsbg_pkg::*;

  logic b_valid;
  logic b_valid_next;
  pos_t b_pos;
  pos_t b_pos_next;
  logic b_wave_only;
  logic take;

  assign out_valid = b_valid;
  assign take      = b_valid && !out_stall;
  assign last      = (b_pos == POS_IDLE_2) || (b_pos == POS_WAVE_B && b_wave_only);
  assign b_free    = !b_valid || (take && last);

  always_comb begin
    latch_before = (b_pos == POS_WAVE_A) || (b_pos == POS_IDLE_1);
    unique case (b_pos)
      POS_WAVE_A: dac_word = rd_a;
      POS_WAVE_B: dac_word = rd_b;
      POS_IDLE_1: dac_word = IDLE_WORD_FIRST;
      POS_IDLE_2: dac_word = IDLE_WORD_SECOND;
      default:    dac_word = IDLE_WORD_FIRST;
    endcase

    b_valid_next = b_valid;
    b_pos_next   = b_pos;
    if (grp.load) begin
      b_valid_next = 1'b1;
      b_pos_next   = grp.idle_only ? POS_IDLE_1 : POS_WAVE_A;
    end else if (take) begin
      if (last) begin
        b_valid_next = 1'b0;
      end else begin
        b_pos_next = pos_t'(b_pos + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_pos   <= POS_WAVE_A;
    end else begin
      b_valid <= b_valid_next;
      b_pos   <= b_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (grp.load) begin
      b_wave_only <= grp.wave_only;
    end
  end

endmodule
